### design/slid_pkg.sv
package slid_pkg;

    // default configuration
    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // fixed field widths of the ports
    localparam int FUNC_W  = 2;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 6;
    localparam int CNT_W   = 7;

    // cells are counted in groups of this many per scan cycle
    localparam int GROUP_N = 8;

    // operation codes
    localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] OP_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] OP_SEARCH = 2'd2;
    localparam logic [FUNC_W-1:0] OP_CLEAR  = 2'd3;

    // control handed to every cell
    typedef struct packed {
        logic cap;   // capture compare flags against the incoming word
        logic ins;   // apply insert (store not full)
        logic del;   // apply delete (match found)
    } t_cell_ctl;

    function automatic logic [3:0] popcount8(input logic [GROUP_N-1:0] bits);
        logic [3:0] sum;
        sum = '0;
        for (int k = 0; k < GROUP_N; k++) begin
            sum = sum + {3'b000, bits[k]};
        end
        return sum;
    endfunction

endpackage

### design/slid_cell.sv
module slid_cell #(
    parameter int VALUE_WIDTH = slid_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  slid_pkg::t_cell_ctl    i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_cmp_key,   // key at accept
    input  logic [VALUE_WIDTH-1:0] i_ins_key,   // held key for insert
    input  logic                   i_occupied,
    input  logic [VALUE_WIDTH-1:0] i_lo_val,    // neighbor one position down
    input  logic                   i_lo_le,
    input  logic [VALUE_WIDTH-1:0] i_hi_val,    // neighbor one position up
    output logic [VALUE_WIDTH-1:0] o_val,
    output logic                   o_lt,
    output logic                   o_le
);

    logic [VALUE_WIDTH-1:0] r_val;
    logic [VALUE_WIDTH-1:0] n_val;
    logic                   r_lt;
    logic                   r_le;

    // flags: entry below / not above the key, occupied cells only
    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_lt <= i_occupied && ($signed(r_val) <  $signed(i_cmp_key));
            r_le <= i_occupied && ($signed(r_val) <= $signed(i_cmp_key));
        end
    end

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins && !r_le) begin
            // first cell above the key takes it, the rest shift up
            n_val = i_lo_le ? i_ins_key : i_lo_val;
        end else if (i_ctl.del && !r_lt) begin
            n_val = i_hi_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_lt  = r_lt;
    assign o_le  = r_le;

endmodule

### design/slid_scan.sv
module slid_scan #(
    parameter int CAPACITY = slid_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [(CAPACITY + slid_pkg::GROUP_N - 1) / slid_pkg::GROUP_N
                  * slid_pkg::GROUP_N - 1:0]    i_lt,
    input  logic [(CAPACITY + slid_pkg::GROUP_N - 1) / slid_pkg::GROUP_N
                  * slid_pkg::GROUP_N - 1:0]    i_le,
    output logic                                o_done,
    output logic [$clog2(CAPACITY + 1)-1:0]     o_nlt,
    output logic [$clog2(CAPACITY + 1)-1:0]     o_nle
);

    localparam int NG = (CAPACITY + slid_pkg::GROUP_N - 1) / slid_pkg::GROUP_N;
    localparam int GW = (NG > 1) ? $clog2(NG) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic          r_busy;
    logic          r_done;
    logic [GW-1:0] r_grp;
    logic [CW-1:0] r_nlt;
    logic [CW-1:0] r_nle;
    logic [3:0]    w_pc_lt;
    logic [3:0]    w_pc_le;
    logic          w_last;

    assign w_pc_lt = slid_pkg::popcount8(i_lt[r_grp*slid_pkg::GROUP_N +: slid_pkg::GROUP_N]);
    assign w_pc_le = slid_pkg::popcount8(i_le[r_grp*slid_pkg::GROUP_N +: slid_pkg::GROUP_N]);
    assign w_last  = (r_grp == GW'(NG - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_grp  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_grp  <= '0;
            end else if (r_busy) begin
                r_grp <= r_grp + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // running counts, one group of cells per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nlt <= '0;
            r_nle <= '0;
        end else if (r_busy) begin
            r_nlt <= r_nlt + CW'(w_pc_lt);
            r_nle <= r_nle + CW'(w_pc_le);
        end
    end

    assign o_done = r_done;
    assign o_nlt  = r_nlt;
    assign o_nle  = r_nle;

endmodule

### design/sorted_list_insert_delete_unit.sv
// Sorted list insert/delete/search unit
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | in        | i_in_valid / o_in_ready    | i_in_func, i_in_value
//  out     | out       | o_out_valid / i_out_ready  | o_out_success, o_out_position,
//          |           |                            | o_out_entry_count, o_out_is_full
//
// Every cell compares its entry with the word at the accept edge; the compare
// state then starts the scan, which counts the flags eight cells at a time and
// raises a done flag, and the update state shifts the cells and loads the result
// register. Ready returns with the result; a new word is taken only then.
// Reset (i_rst_n low, synchronous) empties the list; cell contents are left.
// A stalled result holds the update cycle until the output register frees.
module sorted_list_insert_delete_unit #(
    parameter int CAPACITY    = slid_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = slid_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [slid_pkg::FUNC_W-1:0]   i_in_func,
    input  logic signed [slid_pkg::DATA_W-1:0] i_in_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_out_success,
    output logic [slid_pkg::POS_W-1:0]    o_out_position,
    output logic [slid_pkg::CNT_W-1:0]    o_out_entry_count,
    output logic                          o_out_is_full
);

    localparam int NG = (CAPACITY + slid_pkg::GROUP_N - 1) / slid_pkg::GROUP_N;
    localparam int NP = NG * slid_pkg::GROUP_N;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > slid_pkg::CNT_W) ? CW : slid_pkg::CNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    logic [1:0]                      r_state;
    logic [1:0]                      n_state;
    logic [slid_pkg::FUNC_W-1:0]     r_op;
    logic [VALUE_WIDTH-1:0]          r_key;
    logic [VALUE_WIDTH-1:0]          w_in_key;
    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   n_count;

    logic                            r_out_valid;
    logic                            r_out_success;
    logic [slid_pkg::POS_W-1:0]      r_out_position;
    logic [slid_pkg::CNT_W-1:0]      r_out_count;
    logic                            r_out_full;

    logic                            w_accept;
    logic                            w_commit;
    logic                            w_full;
    logic                            w_found;
    logic                            w_success;
    logic [CW-1:0]                   w_pos;
    logic [XW-1:0]                   w_pos_x;
    logic [XW-1:0]                   w_cnt_x;
    logic                            w_scan_done;
    logic [CW-1:0]                   w_nlt;
    logic [CW-1:0]                   w_nle;
    slid_pkg::t_cell_ctl             w_ctl;

    logic [VALUE_WIDTH-1:0]          w_val [CAPACITY];
    logic [CAPACITY-1:0]             w_lt;
    logic [CAPACITY-1:0]             w_le;
    logic [NP-1:0]                   w_lt_pad;
    logic [NP-1:0]                   w_le_pad;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    // the update lands only when the output register can take the result
    assign w_commit   = (r_state == S_UPD) && (!r_out_valid || i_out_ready);

    // low VALUE_WIDTH bits of the word, zero-padded when the store is wider
    assign w_in_key = VALUE_WIDTH'($unsigned(i_in_value));

    assign w_full  = (r_count == CW'(CAPACITY));
    // a match exists when some occupied entry is equal: le count exceeds lt count
    assign w_found = (w_nle != w_nlt);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_CMP;
            S_CMP:  n_state = S_SCAN;
            S_SCAN: if (w_scan_done) n_state = S_UPD;
            S_UPD:  if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_in_func;
            r_key <= w_in_key;
        end
    end

    // result and next count for the word in hand
    always_comb begin
        n_count   = r_count;
        w_success = 1'b0;
        w_pos     = '0;
        unique case (r_op)
            slid_pkg::OP_INSERT: begin
                if (!w_full) begin
                    n_count   = r_count + 1'b1;
                    w_success = 1'b1;
                    w_pos     = w_nle;     // after any equal entries
                end
            end
            slid_pkg::OP_DELETE: begin
                if (w_found) begin
                    n_count   = r_count - 1'b1;
                    w_success = 1'b1;
                    w_pos     = w_nlt;     // lowest equal entry
                end
            end
            slid_pkg::OP_SEARCH: begin
                if (w_found) begin
                    w_success = 1'b1;
                    w_pos     = w_nlt;
                end
            end
            slid_pkg::OP_CLEAR: begin
                n_count   = '0;
                w_success = 1'b1;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign w_pos_x = XW'(w_pos);
    assign w_cnt_x = XW'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_commit) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_success  <= w_success;
            r_out_position <= w_pos_x[slid_pkg::POS_W-1:0];
            r_out_count    <= w_cnt_x[slid_pkg::CNT_W-1:0];
            r_out_full     <= (n_count == CW'(CAPACITY));
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_success     = r_out_success;
    assign o_out_position    = r_out_position;
    assign o_out_entry_count = r_out_count;
    assign o_out_is_full     = r_out_full;

    // cell control: flags are taken at accept, shifts happen at commit
    assign w_ctl.cap = w_accept;
    assign w_ctl.ins = w_commit && (r_op == slid_pkg::OP_INSERT) && !w_full;
    assign w_ctl.del = w_commit && (r_op == slid_pkg::OP_DELETE) && w_found;

    // the row of cells, position 0 at the bottom
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_lo_val;
        logic                   w_lo_le;
        logic [VALUE_WIDTH-1:0] w_hi_val;

        if (gi == 0) begin : g_bot
            assign w_lo_val = w_val[gi];
            assign w_lo_le  = 1'b1;
        end else begin : g_mid_lo
            assign w_lo_val = w_val[gi-1];
            assign w_lo_le  = w_le[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_top
            assign w_hi_val = w_val[gi];
        end else begin : g_mid_hi
            assign w_hi_val = w_val[gi+1];
        end

        slid_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_cmp_key  (w_in_key),
            .i_ins_key  (r_key),
            .i_occupied (CW'(gi) < r_count),
            .i_lo_val   (w_lo_val),
            .i_lo_le    (w_lo_le),
            .i_hi_val   (w_hi_val),
            .o_val      (w_val[gi]),
            .o_lt       (w_lt[gi]),
            .o_le       (w_le[gi])
        );
    end

    // pad flag rows to whole groups
    for (genvar gj = 0; gj < NP; gj++) begin : g_pad
        if (gj < CAPACITY) begin : g_real
            assign w_lt_pad[gj] = w_lt[gj];
            assign w_le_pad[gj] = w_le[gj];
        end else begin : g_fill
            assign w_lt_pad[gj] = 1'b0;
            assign w_le_pad[gj] = 1'b0;
        end
    end

    slid_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_CMP),
        .i_lt    (w_lt_pad),
        .i_le    (w_le_pad),
        .o_done  (w_scan_done),
        .o_nlt   (w_nlt),
        .o_nle   (w_nle)
    );

endmodule

### sim/slid_checker.sv
`timescale 1ns / 100ps

module slid_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [slid_pkg::FUNC_W-1:0]       i_in_func,
    input  logic signed [slid_pkg::DATA_W-1:0] i_in_value,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic                              i_out_success,
    input  logic [slid_pkg::POS_W-1:0]        i_out_position,
    input  logic [slid_pkg::CNT_W-1:0]        i_out_entry_count,
    input  logic                              i_out_is_full,
    output int                                o_pending,
    output int                                o_mismatch_count,
    output int                                o_checked,
    output int                                o_full_replies
);

    localparam int LIST_DEPTH = slid_pkg::CAPACITY_DEF;

    typedef struct packed {
        logic                         success;
        logic [slid_pkg::POS_W-1:0]   position;
        logic [slid_pkg::CNT_W-1:0]   entry_count;
        logic                         is_full;
    } t_list_reply;

    // shadow copy of the sorted list
    logic signed [slid_pkg::DATA_W-1:0] list_vals [LIST_DEPTH];
    int          list_len = 0;
    t_list_reply reply_queue [$];

    int mismatch_n = 0;
    int checked_n  = 0;
    int full_n     = 0;

    // applies one word to the shadow list, returns the reply it should give
    function automatic t_list_reply apply_list_op(
        input logic [slid_pkg::FUNC_W-1:0]        op,
        input logic signed [slid_pkg::DATA_W-1:0] key
    );
        t_list_reply r;
        int          slot;
        int          hit;
        r    = '0;
        slot = 0;
        hit  = -1;
        case (op)
            slid_pkg::OP_INSERT: begin
                if (list_len < LIST_DEPTH) begin
                    // goes after every equal entry
                    slot = list_len;
                    while (slot > 0 && list_vals[slot-1] > key) begin
                        list_vals[slot] = list_vals[slot-1];
                        slot--;
                    end
                    list_vals[slot] = key;
                    list_len++;
                    r.success  = 1'b1;
                    r.position = slot[slid_pkg::POS_W-1:0];
                end
            end
            slid_pkg::OP_DELETE, slid_pkg::OP_SEARCH: begin
                for (int k = list_len - 1; k >= 0; k--) begin
                    if (list_vals[k] == key) hit = k;
                end
                if (hit >= 0) begin
                    r.success  = 1'b1;
                    r.position = hit[slid_pkg::POS_W-1:0];
                    if (op == slid_pkg::OP_DELETE) begin
                        for (int k = hit; k < list_len - 1; k++) list_vals[k] = list_vals[k+1];
                        list_len--;
                    end
                end
            end
            default: begin
                // clear: stored bits stay, but nothing is valid
                list_len  = 0;
                r.success = 1'b1;
            end
        endcase
        r.entry_count = list_len[slid_pkg::CNT_W-1:0];
        r.is_full     = (list_len == LIST_DEPTH);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_list_reply want;
        t_list_reply seen;
        if (!i_rst_n) begin
            list_len = 0;
            reply_queue.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                reply_queue.push_back(apply_list_op(i_in_func, i_in_value));
            if (i_out_valid && i_out_ready) begin
                seen = '{i_out_success, i_out_position, i_out_entry_count, i_out_is_full};
                if (seen.is_full === 1'b1) full_n++;
                if (reply_queue.size() == 0) begin
                    mismatch_n++;
                    if (mismatch_n <= 10)
                        $display("%t: reply with none pending: success=%0b pos=%0d cnt=%0d full=%0b",
                                 $realtime, seen.success, seen.position, seen.entry_count,
                                 seen.is_full);
                end else begin
                    want = reply_queue.pop_front();
                    checked_n++;
                    if (want.success !== seen.success || want.position !== seen.position ||
                        want.entry_count !== seen.entry_count || want.is_full !== seen.is_full) begin
                        mismatch_n++;
                        if (mismatch_n <= 10) begin
                            $display("%t: reply %0d wrong", $realtime, checked_n);
                            $display("    expected success=%0b pos=%0d cnt=%0d full=%0b",
                                     want.success, want.position, want.entry_count, want.is_full);
                            $display("    actual   success=%0b pos=%0d cnt=%0d full=%0b",
                                     seen.success, seen.position, seen.entry_count, seen.is_full);
                        end
                    end
                end
            end
        end
        o_pending        <= reply_queue.size();
        o_mismatch_count <= mismatch_n;
        o_checked        <= checked_n;
        o_full_replies   <= full_n;
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    // quiet cycles allowed before the run is called hung; a word needs
    // its processing time plus any sender gap and any sink stall
    localparam int QUIET_LIMIT = 2000;
    // random traffic: 8 rounds of 66 words, plus the directed words
    localparam int ROUNDS     = 8;
    localparam int ROUND_LEN  = 66;
    localparam int POOL_N     = 12;
    // settle time after the last reply
    localparam int TAIL_WAIT  = 20;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    typedef enum {MODE_FILL, MODE_MIXED, MODE_DRAIN} t_traffic_mode;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    logic [slid_pkg::FUNC_W-1:0]         in_func;
    logic signed [slid_pkg::DATA_W-1:0]  in_value;
    logic                                out_valid;
    logic                                out_ready = 1'b1;
    logic                                out_success;
    logic [slid_pkg::POS_W-1:0]          out_position;
    logic [slid_pkg::CNT_W-1:0]          out_entry_count;
    logic                                out_is_full;

    int pending;
    int mismatch_count;
    int checked;
    int full_replies;

    // sink side stall control
    logic sink_idle  = 1'b1;
    int   sink_stall = 0;
    int   quiet_cycles = 0;

    int                        op_tally [4];
    logic signed [31:0]        key_pool [POOL_N];

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sorted_list_insert_delete_unit dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_in_func         (in_func),
        .i_in_value        (in_value),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_out_success     (out_success),
        .o_out_position    (out_position),
        .o_out_entry_count (out_entry_count),
        .o_out_is_full     (out_is_full)
    );

    slid_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_in_func         (in_func),
        .i_in_value        (in_value),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_out_success     (out_success),
        .i_out_position    (out_position),
        .i_out_entry_count (out_entry_count),
        .i_out_is_full     (out_is_full),
        .o_pending         (pending),
        .o_mismatch_count  (mismatch_count),
        .o_checked         (checked),
        .o_full_replies    (full_replies)
    );

    // Sink: ready drops for random bursts, started only while sink_idle is set.
    always @(negedge clk) begin
        if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            out_ready  <= 1'b0;
        end else if (sink_idle && $urandom_range(0, 5) == 0) begin
            sink_stall <= $urandom_range(0, 16);
            out_ready  <= 1'b0;
        end else begin
            out_ready  <= 1'b1;
        end
    end

    // Watchdog: counts cycles with no word moving on either channel.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one word right after a falling edge and holds it until the
    // block takes it. Returns on the falling edge after the accept, with
    // valid still high so back-to-back words follow without a gap.
    task automatic put_word(input logic [slid_pkg::FUNC_W-1:0] op,
                            input logic signed [31:0] key);
        in_valid <= 1'b1;
        in_func  <= op;
        in_value <= key;
        op_tally[op]++;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Drops valid and holds off until every reply is back (it always waits on
    // a falling edge first, so valid is never lowered and raised in the same step).
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    // Operation mix per traffic mode: fill runs the list into full and past
    // it, drain runs it dry, mixed sits in between with the odd clear.
    function automatic logic [slid_pkg::FUNC_W-1:0] pick_op(input t_traffic_mode mode);
        int w;
        w = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (w < 94)      return slid_pkg::OP_INSERT;
                else if (w < 98) return slid_pkg::OP_SEARCH;
                else             return slid_pkg::OP_DELETE;
            end
            MODE_MIXED: begin
                if (w < 40)      return slid_pkg::OP_INSERT;
                else if (w < 68) return slid_pkg::OP_DELETE;
                else if (w < 95) return slid_pkg::OP_SEARCH;
                else             return slid_pkg::OP_CLEAR;
            end
            default: begin
                if (w < 12)      return slid_pkg::OP_INSERT;
                else if (w < 78) return slid_pkg::OP_DELETE;
                else if (w < 99) return slid_pkg::OP_SEARCH;
                else             return slid_pkg::OP_CLEAR;
            end
        endcase
    endfunction

    // Values mostly come from a small pool so that duplicates pile up and
    // deletes / searches hit; the rest are extremes or full-range noise.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return 32'sd0;
                    3:       return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            1, 2:    return $urandom;
            default: return key_pool[$urandom_range(0, POOL_N - 1)];
        endcase
    endfunction

    initial begin
        t_traffic_mode mode;
        logic          send_idle;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_func  = slid_pkg::OP_CLEAR;
        in_value = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty-list misses, extremes, duplicate ordering,
        // first-equal delete, delete misses, and clear hiding stale entries.
        put_word(slid_pkg::OP_CLEAR,  32'sd0);
        put_word(slid_pkg::OP_SEARCH, 32'sd0);
        put_word(slid_pkg::OP_DELETE, 32'sd5);
        put_word(slid_pkg::OP_INSERT, 32'sd0);
        put_word(slid_pkg::OP_INSERT, VAL_MIN);
        put_word(slid_pkg::OP_INSERT, VAL_MAX);
        put_word(slid_pkg::OP_INSERT, 32'sd0);    // equal: lands after the first 0
        put_word(slid_pkg::OP_INSERT, -32'sd1);
        put_word(slid_pkg::OP_INSERT, 32'sd1);
        put_word(slid_pkg::OP_SEARCH, 32'sd0);
        put_word(slid_pkg::OP_SEARCH, VAL_MAX);
        put_word(slid_pkg::OP_SEARCH, VAL_MIN);
        put_word(slid_pkg::OP_SEARCH, 32'sd7);
        put_word(slid_pkg::OP_DELETE, 32'sd0);
        put_word(slid_pkg::OP_DELETE, 32'sd0);
        put_word(slid_pkg::OP_DELETE, 32'sd0);    // both gone: miss
        put_word(slid_pkg::OP_DELETE, VAL_MIN);
        put_word(slid_pkg::OP_DELETE, VAL_MAX);
        put_word(slid_pkg::OP_INSERT, 32'sh5555_5555);
        put_word(slid_pkg::OP_INSERT, 32'shaaaa_aaaa);
        put_word(slid_pkg::OP_SEARCH, 32'shaaaa_aaaa);
        put_word(slid_pkg::OP_CLEAR,  32'sd0);
        put_word(slid_pkg::OP_SEARCH, 32'sd1);    // stale bits must not match
        put_word(slid_pkg::OP_DELETE, -32'sd1);
        hold_until_drained();

        // Random rounds: fill, mixed, drain, fill, ... Two fills back to back
        // push the list well past full. Idling varies per round; the last
        // round runs at full rate on both sides.
        for (int r = 0; r < ROUNDS; r++) begin
            case (r % 4)
                1:       mode = MODE_MIXED;
                2:       mode = MODE_DRAIN;
                default: mode = MODE_FILL;
            endcase
            for (int k = 0; k < POOL_N; k++)
                key_pool[k] = (k < POOL_N / 2) ? $signed($urandom_range(0, 40)) - 20 : $urandom;
            send_idle = (r != ROUNDS - 1) && ($urandom_range(0, 2) != 0);
            sink_idle <= (r != ROUNDS - 1) && ($urandom_range(0, 2) != 0);

            for (int i = 0; i < ROUND_LEN; i++) begin
                if (send_idle && $urandom_range(0, 4) == 0) begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 17)) @(negedge clk);
                end
                put_word(pick_op(mode), pick_value());
            end
            // sender waits out every pending reply between rounds
            hold_until_drained();
        end

        repeat (TAIL_WAIT) @(negedge clk);

        $display("Sent %0d words: %0d insert, %0d delete, %0d search, %0d clear.",
                 op_tally[slid_pkg::OP_INSERT] + op_tally[slid_pkg::OP_DELETE] +
                 op_tally[slid_pkg::OP_SEARCH] + op_tally[slid_pkg::OP_CLEAR],
                 op_tally[slid_pkg::OP_INSERT], op_tally[slid_pkg::OP_DELETE],
                 op_tally[slid_pkg::OP_SEARCH], op_tally[slid_pkg::OP_CLEAR]);
        $display("Checked %0d replies, %0d of them with the list full.", checked, full_replies);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
design/slid_pkg.sv
design/slid_cell.sv
design/slid_scan.sv
design/sorted_list_insert_delete_unit.sv
sim/slid_checker.sv
sim/testbench.sv
